>>> hw/rtl/dlof_pkg.sv
// Package for the door light off-delay fader: register indexes, reset
// values, widths and the shared configuration and result types.
// Depends on nothing; every other file of the block but dlof_in_if imports it.
`timescale 1ns / 1ps
`default_nettype none

package dlof_pkg;

	// Widths of the configuration port and of the fields.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TICK_W     = 16;
	localparam int BYTE_W     = 8;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_TICKS   = 3'd0,
		REG_HOLD_PERIODS = 3'd1,
		REG_FADE_DIVIDER = 3'd2,
		REG_FADE_STEP    = 3'd3,
		REG_FADE_MAX     = 3'd4
	} reg_idx_t;

	// Values the registers take at reset.
	localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 16'd7500;
	localparam logic [BYTE_W-1:0] HOLD_PERIODS_RST = 8'd1;
	localparam logic [BYTE_W-1:0] FADE_DIVIDER_RST = 8'd5;
	localparam logic [BYTE_W-1:0] FADE_STEP_RST    = 8'd4;
	localparam logic [BYTE_W-1:0] FADE_MAX_RST     = 8'd200;

	// Current register contents, handed from the register file to the core.
	typedef struct packed {
		logic [TICK_W-1:0] hold_ticks;
		logic [BYTE_W-1:0] hold_periods;
		logic [BYTE_W-1:0] fade_divider;
		logic [BYTE_W-1:0] fade_step;
		logic [BYTE_W-1:0] fade_max;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic              relay_on;
		logic [BYTE_W-1:0] led_level;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/dlof_cfg_if.sv
// Configuration write channel of the door light off-delay fader.
// Depends on dlof_pkg for the index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface dlof_cfg_if
	import dlof_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dlof_in_if.sv
// Input channel of the door light off-delay fader: one tick per transaction.
// Self-contained; carries the sampled door contact.
`timescale 1ns / 1ps
`default_nettype none

interface dlof_in_if;
	logic valid;
	logic ready;
	logic door_open;

	modport source (output valid, output door_open, input ready);
	modport sink (input valid, input door_open, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dlof_out_if.sv
// Result channel of the door light off-delay fader: relay and LED level.
// Depends on dlof_pkg for the level width.
`timescale 1ns / 1ps
`default_nettype none

interface dlof_out_if
	import dlof_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              relay_on;
	logic [BYTE_W-1:0] led_level;

	modport source (output valid, output relay_on, output led_level, input ready);
	modport sink (input valid, input relay_on, input led_level, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dlof_regs.sv
// Configuration register file of the door light off-delay fader.
// Depends on dlof_pkg and the dlof_cfg_if channel.
`timescale 1ns / 1ps
`default_nettype none

module dlof_regs
	import dlof_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	dlof_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;
	logic wr_en;

	// Writes are taken in every cycle.
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid;
	assign regs      = regs_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hold_ticks   <= HOLD_TICKS_RST;
			regs_q.hold_periods <= HOLD_PERIODS_RST;
			regs_q.fade_divider <= FADE_DIVIDER_RST;
			regs_q.fade_step    <= FADE_STEP_RST;
			regs_q.fade_max     <= FADE_MAX_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(cfg.index))
				REG_HOLD_TICKS:   regs_q.hold_ticks   <= cfg.data;
				REG_HOLD_PERIODS: regs_q.hold_periods <= cfg.data[BYTE_W-1:0];
				REG_FADE_DIVIDER: regs_q.fade_divider <= cfg.data[BYTE_W-1:0];
				REG_FADE_STEP:    regs_q.fade_step    <= cfg.data[BYTE_W-1:0];
				REG_FADE_MAX:     regs_q.fade_max     <= cfg.data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/dlof_core.sv
// Timer and fade state of the door light off-delay fader, updated once per
// accepted tick. Depends on dlof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlof_core
	import dlof_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         tick_en,
	input  wire         door_open,
	input  cfg_t        regs,
	output result_t     result
);

	logic              relay_q;
	logic              armed_q;
	logic [TICK_W-1:0] tick_q;
	logic [BYTE_W-1:0] period_q;
	logic              expired_q;
	logic [BYTE_W-1:0] fade_q;
	logic [BYTE_W-1:0] bright_q;

	logic [TICK_W-1:0] tick_inc;
	logic              tick_hit;
	logic [TICK_W-1:0] tick_nxt;
	logic [BYTE_W-1:0] period_inc;
	logic              period_hit;
	logic [BYTE_W-1:0] period_nxt;
	logic              expired_set;
	logic [BYTE_W-1:0] fade_inc;
	logic              fade_hit;
	logic [BYTE_W-1:0] fade_nxt;
	logic [BYTE_W:0]   bright_sum;
	logic [BYTE_W-1:0] bright_nxt;
	logic              relay_nxt;
	logic              armed_nxt;
	logic              expired_nxt;

	// Hold timer: tick counter, then period counter, then the expiry flag.
	always_comb begin
		tick_inc    = armed_q ? tick_q + 16'd1 : tick_q;
		tick_hit    = tick_inc >= regs.hold_ticks;
		tick_nxt    = tick_hit ? tick_inc - regs.hold_ticks : tick_inc;
		period_inc  = period_q + 8'd1;
		period_hit  = tick_hit && (period_inc >= regs.hold_periods);
		if (period_hit) begin
			period_nxt = period_inc - regs.hold_periods;
		end else if (tick_hit) begin
			period_nxt = period_inc;
		end else begin
			period_nxt = period_q;
		end
		expired_set = expired_q | period_hit;
	end

	// Fade prescaler; a wrap steps the brightness in the same tick, so the
	// fade request never outlives the tick that raised it.
	always_comb begin
		fade_inc   = fade_q + 8'd1;
		fade_hit   = fade_inc >= regs.fade_divider;
		fade_nxt   = fade_hit ? fade_inc - regs.fade_divider : fade_inc;
		bright_sum = {1'b0, bright_q} + {1'b0, regs.fade_step};
		bright_nxt = bright_q;
		if (fade_hit) begin
			if (door_open) begin
				if (bright_q < regs.fade_max) begin
					bright_nxt = (bright_sum > {1'b0, regs.fade_max}) ?
						regs.fade_max : bright_sum[BYTE_W-1:0];
				end
			end else begin
				bright_nxt = (bright_q > regs.fade_step) ?
					bright_q - regs.fade_step : '0;
			end
		end
	end

	// Door handling: an open door arms, a closed door lets an expiry disarm.
	always_comb begin
		relay_nxt   = relay_q;
		armed_nxt   = armed_q;
		expired_nxt = expired_set;
		if (door_open) begin
			relay_nxt = 1'b1;
			armed_nxt = 1'b1;
		end else if (expired_set) begin
			expired_nxt = 1'b0;
			relay_nxt   = 1'b0;
			armed_nxt   = 1'b0;
		end
	end

	assign result.relay_on  = relay_nxt;
	assign result.led_level = bright_nxt;

	// State registers, advanced on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q   <= 1'b0;
			armed_q   <= 1'b0;
			tick_q    <= '0;
			period_q  <= '0;
			expired_q <= 1'b0;
			fade_q    <= '0;
			bright_q  <= '0;
		end else if (tick_en) begin
			relay_q   <= relay_nxt;
			armed_q   <= armed_nxt;
			tick_q    <= door_open ? '0 : tick_nxt;
			period_q  <= door_open ? '0 : period_nxt;
			expired_q <= expired_nxt;
			fade_q    <= fade_nxt;
			bright_q  <= bright_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/dlof_outreg.sv
// Result register of the door light off-delay fader with its valid flag.
// Depends on dlof_pkg and the dlof_out_if channel.
`timescale 1ns / 1ps
`default_nettype none

module dlof_outreg
	import dlof_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         load,
	input  result_t     result,
	output logic        free,
	dlof_out_if.source  res
);

	logic    valid_q;
	result_t data_q;

	// The register can take a new result when empty or when it drains now.
	assign free          = !valid_q || res.ready;
	assign res.valid     = valid_q;
	assign res.relay_on  = data_q.relay_on;
	assign res.led_level = data_q.led_level;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/door_light_off_delay_fader_unit.sv
// Staircase light off-delay timer with LED fade.
//
// Channels: tick_in carries one timer tick per transaction with the sampled
// door contact; result_out returns one transaction per tick with the relay
// drive and the LED level after that tick; cfg writes the five registers
// (hold_ticks, hold_periods, fade_divider, fade_step, fade_max at indexes 0
// to 4) and is always ready. Write registers only while no tick is in flight.
//
// The result of a tick accepted at a clock edge is loaded into the result
// register at that edge and is valid after it. One tick per clock is taken
// while the receiver keeps up; the result register decouples the two sides.
//
// Reset clears the timer, fade state and result register and loads the
// register defaults. When the receiver stalls, the pending result holds and
// tick_in.ready stays low until it is taken; a tick is still accepted in the
// cycle the pending result leaves.
//
// Depends on dlof_pkg, the three channel interfaces, dlof_regs, dlof_core
// and dlof_outreg.
`timescale 1ns / 1ps
`default_nettype none

module door_light_off_delay_fader_unit
	import dlof_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	dlof_cfg_if.sink    cfg,
	dlof_in_if.sink     tick_in,
	dlof_out_if.source  result_out
);

	cfg_t    regs;
	result_t result;
	logic    free;
	logic    accept;

	// A tick transaction completes when the result register has room.
	assign tick_in.ready = free;
	assign accept        = tick_in.valid && free;

	// Configuration registers.
	dlof_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Timer and fade state.
	dlof_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_en   (accept),
		.door_open (tick_in.door_open),
		.regs      (regs),
		.result    (result)
	);

	// Result register.
	dlof_outreg u_outreg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.result (result),
		.free   (free),
		.res    (result_out)
	);

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for door_light_off_delay_fader_unit: directed and random tick
// streams with register changes, checked against an in-bench timer/fade model.
// Depends on dlof_pkg, the three channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module tb;
	import dlof_pkg::*;

	localparam int LIMIT = 600000;

	logic clk;
	logic arst_n;

	dlof_cfg_if cfg_if();
	dlof_in_if  tick_if();
	dlof_out_if res_if();

	door_light_off_delay_fader_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_if),
		.tick_in    (tick_if),
		.result_out (res_if)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predictor copy of the registers and of the timer and fade state.
	cfg_t              regs_m;
	logic              relay_m;
	logic              armed_m;
	logic [TICK_W-1:0] tick_cnt_m;
	logic [BYTE_W-1:0] period_cnt_m;
	logic              expired_m;
	logic [BYTE_W-1:0] fade_cnt_m;
	logic              fade_due_m;
	logic [BYTE_W-1:0] level_m;

	// Expected results in tick order, and bookkeeping.
	result_t expected_q[$];
	int      err_cnt;
	int      cycle_cnt;
	int      burst_left;
	bit      tx_idle_on;
	int      rx_stall_left;

	task automatic reset_light_model();
		regs_m.hold_ticks   = HOLD_TICKS_RST;
		regs_m.hold_periods = HOLD_PERIODS_RST;
		regs_m.fade_divider = FADE_DIVIDER_RST;
		regs_m.fade_step    = FADE_STEP_RST;
		regs_m.fade_max     = FADE_MAX_RST;
		relay_m      = 1'b0;
		armed_m      = 1'b0;
		tick_cnt_m   = '0;
		period_cnt_m = '0;
		expired_m    = 1'b0;
		fade_cnt_m   = '0;
		fade_due_m   = 1'b0;
		level_m      = '0;
	endtask

	// Advances the light model by one tick and returns relay and LED level.
	function automatic result_t light_tick(input logic door);
		logic [BYTE_W:0] sum;
		result_t         res;
		// Hold timer: the threshold compare runs even when disarmed.
		if (armed_m)
			tick_cnt_m = tick_cnt_m + 1'b1;
		if (tick_cnt_m >= regs_m.hold_ticks) begin
			tick_cnt_m   = tick_cnt_m - regs_m.hold_ticks;
			period_cnt_m = period_cnt_m + 1'b1;
			if (period_cnt_m >= regs_m.hold_periods) begin
				period_cnt_m = period_cnt_m - regs_m.hold_periods;
				expired_m    = 1'b1;
			end
		end
		// Fade prescaler.
		fade_cnt_m = fade_cnt_m + 1'b1;
		if (fade_cnt_m >= regs_m.fade_divider) begin
			fade_cnt_m = fade_cnt_m - regs_m.fade_divider;
			fade_due_m = 1'b1;
		end
		// Brightness step, saturating at fade_max going up and at zero going down.
		if (fade_due_m) begin
			fade_due_m = 1'b0;
			if (door) begin
				if (level_m < regs_m.fade_max) begin
					sum     = {1'b0, level_m} + {1'b0, regs_m.fade_step};
					level_m = (sum > {1'b0, regs_m.fade_max}) ? regs_m.fade_max : sum[BYTE_W-1:0];
				end
			end else begin
				level_m = (level_m > regs_m.fade_step) ? level_m - regs_m.fade_step : '0;
			end
		end
		// Door handling: open re-arms, closed with expiry switches off.
		if (door) begin
			relay_m      = 1'b1;
			armed_m      = 1'b1;
			tick_cnt_m   = '0;
			period_cnt_m = '0;
		end else if (expired_m) begin
			expired_m = 1'b0;
			relay_m   = 1'b0;
			armed_m   = 1'b0;
		end
		res.relay_on  = relay_m;
		res.led_level = level_m;
		return res;
	endfunction

	// Sends one tick; the sender works in bursts with random gaps between them.
	task automatic send_tick(input logic door);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = 0;
			if (tx_idle_on && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 6);
			if (gap > 0) begin
				tick_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		tick_if.valid     <= 1'b1;
		tick_if.door_open <= door;
		@(posedge clk);
		while (!tick_if.ready)
			@(posedge clk);
		expected_q.push_back(light_tick(door));
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected result has been taken.
	task automatic wait_all_results();
		tick_if.valid <= 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Writes one register; only called while no tick is in flight. Valid stays
	// high on return so that writes can follow back to back; the caller drops it.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_HOLD_TICKS:   regs_m.hold_ticks   = value;
			REG_HOLD_PERIODS: regs_m.hold_periods = value[BYTE_W-1:0];
			REG_FADE_DIVIDER: regs_m.fade_divider = value[BYTE_W-1:0];
			REG_FADE_STEP:    regs_m.fade_step    = value[BYTE_W-1:0];
			REG_FADE_MAX:     regs_m.fade_max     = value[BYTE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Writes all five registers; 8-bit registers get junk in the unused upper bits.
	task automatic write_all_regs(input logic [TICK_W-1:0] ticks, input logic [BYTE_W-1:0] periods,
			input logic [BYTE_W-1:0] divider, input logic [BYTE_W-1:0] step,
			input logic [BYTE_W-1:0] max_level);
		logic [BYTE_W-1:0] junk;
		wait_all_results();
		junk = 8'($urandom);
		write_reg(REG_HOLD_TICKS, ticks);
		write_reg(REG_HOLD_PERIODS, {junk, periods});
		write_reg(REG_FADE_DIVIDER, {~junk, divider});
		write_reg(REG_FADE_STEP, {junk, step});
		write_reg(REG_FADE_MAX, {8'hFF, max_level});
		cfg_if.valid <= 1'b0;
	endtask

	// Default registers after reset: fade up while open, down once closed.
	task automatic test_reset_defaults();
		repeat (6) send_tick(1'b1);
		repeat (5) send_tick(1'b0);
	endtask

	// Hold timer expiry after the door closes, and expiry while still open.
	task automatic test_hold_expiry();
		write_all_regs(16'd2, 8'd2, 8'd1, 8'd255, 8'd255);
		repeat (2) send_tick(1'b1);
		repeat (6) send_tick(1'b0);
		write_all_regs(16'd1, 8'd1, 8'd1, 8'd1, 8'd255);
		repeat (2) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// Zero registers, zero step, and a level above a lowered fade_max.
	task automatic test_zero_and_limits();
		write_all_regs(16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		write_all_regs(16'hFFFF, 8'd255, 8'd1, 8'd200, 8'd255);
		repeat (2) send_tick(1'b1);
		write_all_regs(16'hFFFF, 8'd255, 8'd1, 8'd1, 8'd10);
		repeat (2) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// Random register settings, each followed by open/closed door sequences.
	task automatic test_random_phases();
		logic [TICK_W-1:0] ticks;
		logic [BYTE_W-1:0] periods;
		logic [BYTE_W-1:0] divider;
		logic [BYTE_W-1:0] step;
		logic [BYTE_W-1:0] max_level;
		int                sent;
		int                run;
		int                hold_len;
		for (int ph = 0; ph < 8; ph++) begin
			// Mostly short hold times so the relay actually turns off.
			case (ph)
				0: begin ticks = 16'hFFFF; periods = 8'd255; divider = 8'd255;
					step = 8'd255; max_level = 8'd255; end
				1: begin ticks = 16'd1; periods = 8'd1; divider = 8'd1;
					step = 8'd1; max_level = 8'd0; end
				default: begin
					ticks     = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
					periods   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 5));
					divider   = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
					step      = 8'($urandom_range(0, 255));
					max_level = 8'($urandom_range(0, 255));
				end
			endcase
			write_all_regs(ticks, periods, divider, step, max_level);
			tx_idle_on = (ph % 3) != 1;
			sent = 0;
			while (sent < 160) begin
				if ($urandom_range(0, 6) == 0) begin
					// Noise: random door samples.
					run = $urandom_range(1, 10);
					repeat (run) send_tick(1'($urandom));
				end else begin
					// Door open for a while, then closed for about the hold time.
					run = $urandom_range(1, 8);
					repeat (run) send_tick(1'b1);
					hold_len = int'(ticks) * int'(periods);
					if (hold_len > 70 || $urandom_range(0, 4) == 0)
						hold_len = $urandom_range(1, 70);
					hold_len = hold_len + $urandom_range(0, 4);
					repeat (hold_len) send_tick(1'b0);
					run = run + hold_len;
				end
				sent = sent + run;
				// Now and then the sender waits for the result side to drain.
				if ($urandom_range(0, 9) == 0)
					wait_all_results();
			end
		end
	endtask

	// Receiver stalls; the pattern shifts with the cycle count.
	always @(negedge clk) begin
		if (rx_stall_left != 0) begin
			rx_stall_left--;
			res_if.ready <= 1'b0;
		end else begin
			case (cycle_cnt[10:9])
				2'd0: rx_stall_left = 0;
				2'd1: rx_stall_left = ($urandom_range(0, 3) == 0) ? 1 : 0;
				2'd2: rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : 0;
				default: rx_stall_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 0;
			endcase
			res_if.ready <= (rx_stall_left == 0);
		end
	end

	// Each result transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, relay_on %0b led_level %0d", $time,
					res_if.relay_on, res_if.led_level);
				err_cnt++;
			end else begin
				exp_res = expected_q.pop_front();
				if (res_if.relay_on !== exp_res.relay_on) begin
					$display("%0t: relay_on mismatch, expected %0b, actual %0b", $time,
						exp_res.relay_on, res_if.relay_on);
					err_cnt++;
				end
				if (res_if.led_level !== exp_res.led_level) begin
					$display("%0t: led_level mismatch, expected %0d, actual %0d", $time,
						exp_res.led_level, res_if.led_level);
					err_cnt++;
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		err_cnt       = 0;
		cycle_cnt     = 0;
		burst_left    = 0;
		tx_idle_on    = 1'b1;
		rx_stall_left = 0;
		arst_n            = 1'b0;
		tick_if.valid     = 1'b0;
		tick_if.door_open = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = REG_HOLD_TICKS;
		cfg_if.data       = '0;
		res_if.ready      = 1'b1;
		reset_light_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_hold_expiry();
		test_zero_and_limits();
		test_random_phases();

		// Drain, then give the result register time to show anything stray.
		wait_all_results();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
